@@ hw/rtl/slu_pkg.sv @@
// Shared constants, state encoding and status type for the saturating LCM unit.
package slu_pkg;

  // Width of the operand and result fields on the item channels.
  localparam int FIELD_WIDTH = 64;

  // Configuration port geometry.
  localparam int CFG_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 2;
  localparam int WIDTH_REG_BITS = 7;

  // Register map.
  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_OPERAND_WIDTH = 2'd0;
  localparam logic [WIDTH_REG_BITS-1:0] OPERAND_WIDTH_RESET = 7'd64;

  // Sequencer states of the iterative core.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SCALE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } slu_state_t;

  // Status from the core to the channel logic.
  typedef struct packed {
    logic idle;
    logic done;
    logic saturated;
  } slu_status_t;

endpackage

@@ hw/rtl/slu_ifs.sv @@
// Item channel interfaces for the operand and result sides of the LCM unit.
interface slu_in_if;
  import slu_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] first_operand;
  logic [FIELD_WIDTH-1:0] second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

interface slu_out_if;
  import slu_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] multiple;
  logic                   saturated;

  modport source (output valid, output multiple, output saturated, input ready);
  modport sink   (input valid, input multiple, input saturated, output ready);
endinterface

@@ hw/rtl/slu_core.sv @@
// Iterative core: binary GCD, restoring division and shift-add multiply on one datapath.
module slu_core #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   take,
  input  logic [MAX_WIDTH-1:0]   a,
  input  logic [MAX_WIDTH-1:0]   b,
  input  logic [MAX_WIDTH-1:0]   mask,
  output slu_pkg::slu_status_t   status,
  output logic [MAX_WIDTH-1:0]   result
);
  import slu_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_WIDTH + 1);

  slu_state_t state, state_next;

  logic [MAX_WIDTH-1:0] x, x_next;
  logic [MAX_WIDTH-1:0] y, y_next;
  logic [MAX_WIDTH-1:0] opa, opa_next;
  logic [MAX_WIDTH-1:0] dvd, dvd_next;
  logic [MAX_WIDTH-1:0] rem, rem_next;
  logic [MAX_WIDTH-1:0] acc, acc_next;
  logic [CNT_BITS-1:0]  k, k_next;
  logic [CNT_BITS-1:0]  cnt, cnt_next;
  logic                 ovf, ovf_next;

  logic [MAX_WIDTH-1:0] diff_xy, diff_yx;
  logic [MAX_WIDTH:0]   rem_sh, rem_sub;
  logic                 rem_ge;
  logic [MAX_WIDTH+1:0] mul_sum;
  logic                 mul_over;

  // The dividend bit and the multiplier bit both come from the top of dvd.
  assign diff_xy  = x - y;
  assign diff_yx  = y - x;
  assign rem_sh   = {rem, dvd[MAX_WIDTH-1]};
  assign rem_ge   = rem_sh >= {1'b0, x};
  assign rem_sub  = rem_sh - {1'b0, x};
  assign mul_sum  = {1'b0, acc, 1'b0}
                  + (MAX_WIDTH+2)'(dvd[MAX_WIDTH-1] ? opa : '0);
  assign mul_over = mul_sum > (MAX_WIDTH+2)'(mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    x   <= x_next;
    y   <= y_next;
    opa <= opa_next;
    dvd <= dvd_next;
    rem <= rem_next;
    acc <= acc_next;
    k   <= k_next;
    cnt <= cnt_next;
    ovf <= ovf_next;
  end

  always_comb begin
    state_next = state;
    x_next     = x;
    y_next     = y;
    opa_next   = opa;
    dvd_next   = dvd;
    rem_next   = rem;
    acc_next   = acc;
    k_next     = k;
    cnt_next   = cnt;
    ovf_next   = ovf;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          opa_next = a;
          x_next   = a;
          y_next   = b;
          dvd_next = b;
          k_next   = '0;
          acc_next = '0;
          ovf_next = 1'b0;
          if (a == '0 || b == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (x == '0 || y == '0) begin
          x_next     = x | y;
          state_next = ST_SCALE;
        end else begin
          priority if (!x[0] && !y[0]) begin
            x_next = x >> 1;
            y_next = y >> 1;
            k_next = k + CNT_BITS'(1);
          end else if (!x[0]) begin
            x_next = x >> 1;
          end else if (!y[0]) begin
            y_next = y >> 1;
          end else if (x >= y) begin
            x_next = diff_xy;
          end else begin
            y_next = diff_yx;
          end
        end
      end
      ST_SCALE: begin
        // Restore the common power of two into the divisor.
        if (k == '0) begin
          rem_next   = '0;
          cnt_next   = CNT_BITS'(MAX_WIDTH);
          state_next = ST_DIV;
        end else begin
          x_next = x << 1;
          k_next = k - CNT_BITS'(1);
        end
      end
      ST_DIV: begin
        rem_next = rem_ge ? rem_sub[MAX_WIDTH-1:0] : rem_sh[MAX_WIDTH-1:0];
        dvd_next = {dvd[MAX_WIDTH-2:0], rem_ge};
        cnt_next = cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          cnt_next   = CNT_BITS'(MAX_WIDTH);
          acc_next   = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        // Most significant quotient bit first; the partial product only grows,
        // so once it passes the mask the result is saturated.
        dvd_next = dvd << 1;
        if (!ovf) begin
          if (mul_over) begin
            ovf_next = 1'b1;
          end else begin
            acc_next = mul_sum[MAX_WIDTH-1:0];
          end
        end
        cnt_next = cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign status.idle      = (state == ST_IDLE);
  assign status.done      = (state == ST_DONE);
  assign status.saturated = ovf;
  assign result           = ovf ? mask : acc;

endmodule

@@ hw/rtl/saturating_lcm_unit.sv @@
// Top level of the saturating LCM unit: configuration register, channels and core.
// Per item, the core runs the binary GCD loop (data dependent), restores each common
// factor of two, then runs MAX_WIDTH division steps and MAX_WIDTH multiply steps.
// Items: the core holds one item at a time and takes a new one only while idle.
// Reset (rst, synchronous): operand_width returns to 64, the core goes idle and
// no result is pending.
module saturating_lcm_unit #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [slu_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [slu_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output logic [slu_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output logic                                 pready,
  slu_in_if.sink                               operands,
  slu_out_if.source                            results
);
  import slu_pkg::*;

  localparam int W_BITS = $clog2(MAX_WIDTH + 1);

  logic [WIDTH_REG_BITS-1:0] operand_width;
  logic                      cfg_write;
  logic [W_BITS-1:0]         eff_width;
  logic [MAX_WIDTH-1:0]      mask;
  logic [MAX_WIDTH-1:0]      a_masked;
  logic [MAX_WIDTH-1:0]      b_masked;
  logic                      start;
  logic                      take;
  slu_status_t               status;
  logic [MAX_WIDTH-1:0]      core_result;

  logic                      out_valid;
  logic [FIELD_WIDTH-1:0]    out_multiple;
  logic                      out_saturated;

  // The register port never stalls. Writes to any address other than the
  // operand width register are dropped, and such reads return zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == ADDR_OPERAND_WIDTH) ? CFG_DATA_WIDTH'(operand_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_width <= OPERAND_WIDTH_RESET;
    end else if (cfg_write && paddr == ADDR_OPERAND_WIDTH) begin
      operand_width <= pwdata[WIDTH_REG_BITS-1:0];
    end
  end

  // A width of zero behaves as one bit, and anything above the datapath width
  // is clamped to it. The mask keeps the low eff_width bits.
  always_comb begin
    if (operand_width == '0) begin
      eff_width = W_BITS'(1);
    end else if (operand_width > WIDTH_REG_BITS'(MAX_WIDTH)) begin
      eff_width = W_BITS'(MAX_WIDTH);
    end else begin
      eff_width = W_BITS'(operand_width);
    end
  end

  assign mask     = {MAX_WIDTH{1'b1}} >> (W_BITS'(MAX_WIDTH) - eff_width);
  assign a_masked = MAX_WIDTH'(operands.first_operand) & mask;
  assign b_masked = MAX_WIDTH'(operands.second_operand) & mask;

  // An item is taken only while the core is idle. A finished result moves
  // into the output register as soon as that register is free or being
  // drained, so the core can start the next item while the result waits.
  assign operands.ready = status.idle;
  assign start          = operands.valid && operands.ready;
  assign take           = status.done && (!out_valid || results.ready);

  slu_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .take   (take),
    .a      (a_masked),
    .b      (b_masked),
    .mask   (mask),
    .status (status),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_multiple  <= FIELD_WIDTH'(core_result);
      out_saturated <= status.saturated;
    end
  end

  assign results.valid     = out_valid;
  assign results.multiple  = out_multiple;
  assign results.saturated = out_saturated;

endmodule
